@@ hw/rtl/ybc_pkg.sv @@
`default_nettype none

package ybc_pkg;

   // fixed point: 14 fraction bits, channel sums held in 25 signed bits
   localparam int FracBits  = 14;
   localparam int SumWidth  = 25;
   localparam int PixWidth  = 8;

   typedef logic signed [SumWidth-1:0] sum_type;
   typedef logic [PixWidth-1:0]        pix_type;

   localparam sum_type CoefRedCr   = 25'sd22970;
   localparam sum_type CoefGreenCb = 25'sd5638;
   localparam sum_type CoefGreenCr = 25'sd11700;
   localparam sum_type CoefBlueCb  = 25'sd29032;

   localparam logic signed [PixWidth:0] LumaOffset   = 9'sd16;
   localparam logic signed [PixWidth:0] ChromaOffset = 9'sd128;

   typedef struct packed {
      pix_type luma_first;
      pix_type chroma_blue;
      pix_type luma_second;
      pix_type chroma_red;
      logic    frame_end;
   } req_payload_type;

   typedef struct packed {
      pix_type blue_first;
      pix_type green_first;
      pix_type red_first;
      pix_type blue_second;
      pix_type green_second;
      pix_type red_second;
      logic    frame_end_out;
   } rsp_payload_type;

   // chroma contributions shared by both pixels of a macropixel
   typedef struct packed {
      sum_type blue_term;
      sum_type green_term;
      sum_type red_term;
   } chroma_terms_type;

endpackage

`default_nettype wire

@@ hw/rtl/ybc_chan_if.sv @@
`default_nettype none

interface ybc_req_if;
   import ybc_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ybc_rsp_if;
   import ybc_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ybc_chroma.sv @@
`default_nettype none

module ybc_chroma (
   input  wire  ybc_pkg::pix_type          chroma_blue,
   input  wire  ybc_pkg::pix_type          chroma_red,
   output ybc_pkg::chroma_terms_type       terms
);
   import ybc_pkg::*;

   logic signed [PixWidth:0] cb_s;
   logic signed [PixWidth:0] cr_s;
   sum_type                  cb_w;
   sum_type                  cr_w;

   always_comb begin
      cb_s = $signed({1'b0, chroma_blue}) - ChromaOffset;
      cr_s = $signed({1'b0, chroma_red}) - ChromaOffset;
      cb_w = sum_type'(cb_s);
      cr_w = sum_type'(cr_s);
      terms.blue_term  = sum_type'(CoefBlueCb * cb_w);
      terms.green_term = sum_type'(-(CoefGreenCb * cb_w) - (CoefGreenCr * cr_w));
      terms.red_term   = sum_type'(CoefRedCr * cr_w);
   end

endmodule

`default_nettype wire

@@ hw/rtl/ybc_pixel.sv @@
`default_nettype none

module ybc_pixel (
   input  wire  ybc_pkg::pix_type          luma,
   input  wire  ybc_pkg::chroma_terms_type terms,
   output ybc_pkg::pix_type                blue,
   output ybc_pkg::pix_type                green,
   output ybc_pkg::pix_type                red
);
   import ybc_pkg::*;

   // positive sums truncate by a plain shift; anything past 255 saturates
   function automatic pix_type clamp_sum(sum_type s);
      pix_type res;
      if (s[SumWidth-1] || (s == '0)) begin
         res = '0;
      end else if (|s[SumWidth-2:FracBits+PixWidth]) begin
         res = '1;
      end else begin
         res = s[FracBits+PixWidth-1:FracBits];
      end
      return res;
   endfunction

   logic signed [PixWidth:0] luma_s;
   sum_type                  base;

   always_comb begin
      luma_s = $signed({1'b0, luma}) - LumaOffset;
      base   = sum_type'(luma_s) <<< FracBits;
      blue   = clamp_sum(base + terms.blue_term);
      green  = clamp_sum(base + terms.green_term);
      red    = clamp_sum(base + terms.red_term);
   end

endmodule

`default_nettype wire

@@ hw/rtl/yuyv_to_bgr_converter.sv @@
`default_nettype none

// Converts one packed YUYV 4:2:2 macropixel per transaction into the blue,
// green and red bytes of its two pixels (BT.601, luma offset 16 without range
// scaling, chroma offset 128, 14-bit fixed point, truncated and clamped to
// 0..255); the end-of-frame flag rides along unchanged. The block takes one
// macropixel every clock cycle unless the result side holds it back; each
// macropixel passes through the input register and then the result register,
// with the colour arithmetic between them. The input side stays ready while
// the result register holds a transaction, as long as the result can move on
// or the input register is empty. There is no state between items and no
// configuration.
module yuyv_to_bgr_converter (
   input wire       clock,
   input wire       reset,
   ybc_req_if.sink  req_bus,
   ybc_rsp_if.source rsp_bus
);
   import ybc_pkg::*;

   req_payload_type  req_ff;
   logic             req_valid_ff;
   logic             req_valid_in;
   rsp_payload_type  rsp_ff;
   rsp_payload_type  rsp_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             rsp_load;
   logic             req_load;
   chroma_terms_type terms;

   assign rsp_load = req_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !req_valid_ff || rsp_load;
   assign req_load = req_bus.valid && req_bus.ready;

   assign req_valid_in = req_load || (req_valid_ff && !rsp_load);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_bus.ready);

   ybc_chroma u_chroma (
      .chroma_blue (req_ff.chroma_blue),
      .chroma_red  (req_ff.chroma_red),
      .terms       (terms)
   );

   ybc_pixel u_pixel_first (
      .luma  (req_ff.luma_first),
      .terms (terms),
      .blue  (rsp_in.blue_first),
      .green (rsp_in.green_first),
      .red   (rsp_in.red_first)
   );

   ybc_pixel u_pixel_second (
      .luma  (req_ff.luma_second),
      .terms (terms),
      .blue  (rsp_in.blue_second),
      .green (rsp_in.green_second),
      .red   (rsp_in.red_second)
   );

   assign rsp_in.frame_end_out = req_ff.frame_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_load) begin
         req_ff <= req_bus.payload;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_ff;

   // an occupied input register that cannot move on keeps its transaction
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !rsp_load) |=> (req_valid_ff && $stable(req_ff)))
      else $error("input register changed while stalled");

   // the flag in the result register is the one that sat in the input register
   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_ff.frame_end_out == $past(req_ff.frame_end)))
      else $error("end-of-frame flag lost between stages");

   // an empty input register never refuses a transaction
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !req_valid_ff |-> req_bus.ready)
      else $error("input refused with empty input register");

   // a result cannot be overwritten while it still waits downstream
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |-> !rsp_load)
      else $error("pending result overwritten");

endmodule

`default_nettype wire

@@ verif/yuyv_to_bgr_converter_test.sv @@
`default_nettype none

module yuyv_to_bgr_converter_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ybc_pkg::*;

   // BT.601 coefficients, 14 fraction bits
   localparam int UnitScale    = 16384;
   localparam int KBlueCb      = 29032;
   localparam int KGreenCb     = 5638;
   localparam int KGreenCr     = 11700;
   localparam int KRedCr       = 22970;
   localparam int LumaBias     = 16;
   localparam int ChromaBias   = 128;
   localparam int IdlePercent  = 22;
   localparam int HoldOffCycles = 200;
   localparam int StallLimit   = 1000;
   localparam int FlushCycles  = 8;

   logic clock;
   logic reset;

   ybc_req_if req_bus ();
   ybc_rsp_if rsp_bus ();

   yuyv_to_bgr_converter dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   rsp_payload_type expected_bgr[$];
   int  mismatch_count = 0;
   int  quiet_cycles   = 0;
   int  hold_requests  = 0;
   bit  steady_flow    = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic pix_type channel_byte(int sum);
      int whole;
      if (sum <= 0) return '0;
      whole = sum / UnitScale;
      if (whole > 255) return 8'd255;
      return whole[7:0];
   endfunction

   function automatic rsp_payload_type predict_bgr(req_payload_type px);
      rsp_payload_type bgr;
      int cb, cr, base_first, base_second, blue_term, green_term, red_term;
      cb          = int'(px.chroma_blue) - ChromaBias;
      cr          = int'(px.chroma_red) - ChromaBias;
      base_first  = (int'(px.luma_first) - LumaBias) * UnitScale;
      base_second = (int'(px.luma_second) - LumaBias) * UnitScale;
      blue_term   = KBlueCb * cb;
      green_term  = -(KGreenCb * cb) - KGreenCr * cr;
      red_term    = KRedCr * cr;
      bgr.blue_first    = channel_byte(base_first + blue_term);
      bgr.green_first   = channel_byte(base_first + green_term);
      bgr.red_first     = channel_byte(base_first + red_term);
      bgr.blue_second   = channel_byte(base_second + blue_term);
      bgr.green_second  = channel_byte(base_second + green_term);
      bgr.red_second    = channel_byte(base_second + red_term);
      bgr.frame_end_out = px.frame_end;
      return bgr;
   endfunction

   function void compare_field(string field, int want, int got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endfunction

   // scoreboard and watchdog, sampled at the rising edge
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      if (!reset) begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got = rsp_bus.payload;
            if (expected_bgr.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
            end else begin
               want = expected_bgr.pop_front();
               compare_field("blue_first", want.blue_first, got.blue_first);
               compare_field("green_first", want.green_first, got.green_first);
               compare_field("red_first", want.red_first, got.red_first);
               compare_field("blue_second", want.blue_second, got.blue_second);
               compare_field("green_second", want.green_second, got.green_second);
               compare_field("red_second", want.red_second, got.red_second);
               compare_field("frame_end_out", want.frame_end_out, got.frame_end_out);
            end
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
            expected_bgr.push_back(predict_bgr(req_bus.payload));
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= StallLimit) begin
            $display("%0t: no transaction for %0d cycles", $time, StallLimit);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // result side: random back-pressure, with long hold-offs on request
   initial begin
      int holds_served;
      holds_served = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != hold_requests) begin
            holds_served++;
            rsp_bus.ready <= 1'b0;
            repeat (HoldOffCycles) @(negedge clock);
         end
         rsp_bus.ready <= steady_flow || ($urandom_range(99) >= IdlePercent);
      end
   end

   // called at a falling edge, returns at the falling edge after the transaction
   task automatic send_macropixel(input req_payload_type item);
      if (!steady_flow && $urandom_range(99) < IdlePercent) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= item;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      while (expected_bgr.size() != 0) @(negedge clock);
   endtask

   function automatic req_payload_type random_macropixel();
      req_payload_type px;
      px.luma_first  = pix_type'($urandom_range(0, 255));
      px.chroma_blue = pix_type'($urandom_range(0, 255));
      px.luma_second = pix_type'($urandom_range(0, 255));
      px.chroma_red  = pix_type'($urandom_range(0, 255));
      px.frame_end   = ($urandom_range(0, 31) == 0);
      return px;
   endfunction

   task automatic test_directed_corners();
      send_macropixel({8'd0, 8'd0, 8'd0, 8'd0, 1'b0});
      send_macropixel({8'd255, 8'd255, 8'd255, 8'd255, 1'b1});
      // black and nominal white, neutral chroma
      send_macropixel({8'd16, 8'd128, 8'd16, 8'd128, 1'b0});
      send_macropixel({8'd235, 8'd128, 8'd235, 8'd128, 1'b0});
      // positive sums under one unit truncate to zero
      send_macropixel({8'd16, 8'd127, 8'd16, 8'd128, 1'b0});
      send_macropixel({8'd16, 8'd128, 8'd16, 8'd129, 1'b0});
      send_macropixel({8'd17, 8'd128, 8'd15, 8'd128, 1'b1});
      // saturation of each channel
      send_macropixel({8'd255, 8'd255, 8'd0, 8'd128, 1'b0});
      send_macropixel({8'd0, 8'd128, 8'd255, 8'd255, 1'b0});
      send_macropixel({8'd255, 8'd0, 8'd255, 8'd0, 1'b0});
      // negative sums clamp to zero
      send_macropixel({8'd0, 8'd0, 8'd16, 8'd0, 1'b0});
      send_macropixel({8'hAA, 8'h55, 8'h55, 8'hAA, 1'b1});
      send_macropixel({8'h55, 8'hAA, 8'hAA, 8'h55, 1'b0});
      send_macropixel({8'd128, 8'd128, 8'd128, 8'd128, 1'b1});
      send_macropixel({8'd1, 8'd254, 8'd254, 8'd1, 1'b1});
   endtask

   task automatic test_random_pixels(input int count);
      repeat (count) send_macropixel(random_macropixel());
   endtask

   task automatic test_full_rate(input int count);
      steady_flow = 1'b1;
      repeat (count) send_macropixel(random_macropixel());
      steady_flow = 1'b0;
   endtask

   task automatic test_output_hold_off();
      // the pipeline fills and the input must stall until the hold ends
      hold_requests++;
      repeat (30) send_macropixel(random_macropixel());
   endtask

   task automatic test_pause_until_drained();
      repeat (150) send_macropixel(random_macropixel());
      wait_for_drain();
      repeat (150) send_macropixel(random_macropixel());
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_corners();
      test_random_pixels(800);
      test_full_rate(300);
      test_output_hold_off();
      test_pause_until_drained();
      test_random_pixels(100);

      wait_for_drain();
      repeat (FlushCycles) @(negedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
hw/rtl/ybc_pkg.sv
hw/rtl/ybc_chan_if.sv
hw/rtl/ybc_chroma.sv
hw/rtl/ybc_pixel.sv
hw/rtl/yuyv_to_bgr_converter.sv
verif/yuyv_to_bgr_converter_test.sv
